// ===== hw/rtl/battery_level_monitor_defines.svh =====
// assertion helpers for the battery level monitor
`ifndef BATTERY_LEVEL_MONITOR_DEFINES_SVH
`define BATTERY_LEVEL_MONITOR_DEFINES_SVH

// condition holds in the same cycle
`define BLM_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("battery_level_monitor assertion failed");

// condition holds in the following cycle
`define BLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("battery_level_monitor assertion failed");

`endif

// ===== hw/rtl/blm_pkg.sv =====
package blm_pkg;

    localparam int WINDOW_DEPTH_DEF = 4;

    localparam int MV_W    = 13;
    localparam int LEVEL_W = 7;
    localparam int BSTATE_W = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [MV_W-1:0] MV_LOW  = 13'd3200;
    localparam logic [MV_W-1:0] MV_STEP = 13'd100;
    localparam int SOC_STEPS = 10;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 7'd5;
    localparam logic [7:0] REPORTED_LEVEL_RST = 8'd255;
    localparam logic [2:0] REPORTED_STATE_NONE = 3'd7;

    // register word index taken from paddr[2]
    localparam logic REG_CHANGE_THRESHOLD = 1'b0;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_WAKE   = 1'b1;

    localparam logic [1:0] CHG_ACTIVE = 2'd1;
    localparam logic [1:0] CHG_FULL   = 2'd2;

    localparam logic [BSTATE_W-1:0] BS_IDLE     = 2'd0;
    localparam logic [BSTATE_W-1:0] BS_CHARGING = 2'd1;
    localparam logic [BSTATE_W-1:0] BS_FULL     = 2'd2;
    localparam logic [BSTATE_W-1:0] BS_ERROR    = 2'd3;

    localparam logic [LEVEL_W-1:0] SOC_TABLE [SOC_STEPS] =
        '{7'd0, 7'd2, 7'd4, 7'd8, 7'd15, 7'd30, 7'd50, 7'd70, 7'd90, 7'd100};

    typedef struct packed {
        logic            cmd;
        logic [MV_W-1:0] sample_mv;
        logic            read_ok;
        logic            charger_valid;
        logic [1:0]      charge_status;
    } blm_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level_percent;
        logic [BSTATE_W-1:0] battery_state;
    } blm_out_t;

    typedef struct packed {
        logic            start;
        logic [MV_W-1:0] mv;
    } seq_ctrl_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [MV_W-1:0] mean;
    } seq_stat_t;

    // table entry at or below the mean, saturating at both ends
    function automatic logic [LEVEL_W-1:0] soc_level(input logic [MV_W-1:0] mean);
        logic [3:0]      idx;
        logic [MV_W-1:0] thr;
        idx = 4'd0;
        for (int k = 1; k < SOC_STEPS; k++)
        begin
            thr = MV_W'(int'(MV_LOW) + k * int'(MV_STEP));
            if (mean >= thr)
            begin
                idx = 4'(k);
            end
        end
        return SOC_TABLE[idx];
    endfunction

endpackage

// ===== hw/rtl/blm_window.sv =====
module blm_window #(
    parameter int WINDOW_DEPTH = blm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                                   clk,
    input  logic                                                   wr_en,
    input  logic [(WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1)-1:0] wr_addr,
    input  logic [blm_pkg::MV_W-1:0]                               wr_data,
    input  logic [(WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1)-1:0] rd_addr,
    output logic [blm_pkg::MV_W-1:0]                               rd_data
);

    logic [blm_pkg::MV_W-1:0] mem [WINDOW_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/blm_seq.sv =====
module blm_seq #(
    parameter int WINDOW_DEPTH = blm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  blm_pkg::seq_ctrl_t    ctrl,
    output blm_pkg::seq_stat_t    stat
);

    localparam int IDX_W  = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = blm_pkg::MV_W + $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(SUM_W + 1);

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_DEPTH);
    localparam logic [IDX_W-1:0]  WP_LAST  = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(SUM_W - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  wp_reg, wp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic              issue_reg, issue_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [FILL_W-1:0] rem_reg, rem_next;

    logic                     wr_en;
    logic [blm_pkg::MV_W-1:0] rd_data;
    logic [FILL_W:0]          trial;
    logic [SUM_W-1:0]         alu_a;
    logic [SUM_W-1:0]         alu_b;
    logic                     alu_sub;
    logic [SUM_W:0]           alu_res;

    assign wr_en = ctrl.start && (state_reg == S_IDLE);

    blm_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (ctrl.mv),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // shared add/subtract unit: accumulate in sum, trial subtract in divide
    assign trial = {rem_reg, acc_reg[SUM_W-1]};

    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            alu_a   = SUM_W'(trial);
            alu_b   = SUM_W'(fill_reg);
            alu_sub = 1'b1;
        end
        else
        begin
            alu_a   = acc_reg;
            alu_b   = SUM_W'(rd_data);
            alu_sub = 1'b0;
        end
    end

    assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                             : ({1'b0, alu_a} + {1'b0, alu_b});

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        issue_next = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    wp_next    = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
                    fill_next  = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + 1'b1;
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (issue_reg)
                begin
                    acc_next = alu_res[SUM_W-1:0];
                end
                if (idx_reg < fill_reg)
                begin
                    issue_next = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end
                else if (!issue_reg)
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (alu_res[SUM_W])
                begin
                    rem_next = trial[FILL_W-1:0];
                    acc_next = {acc_reg[SUM_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = alu_res[FILL_W-1:0];
                    acc_next = {acc_reg[SUM_W-2:0], 1'b1};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
            issue_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            issue_reg <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign stat.mean = acc_reg[blm_pkg::MV_W-1:0];

endmodule

// ===== hw/rtl/battery_level_monitor.sv =====
// a good sample reaches evaluation after the window sum and the bit-per-cycle
// divider; a read error goes to evaluation straight from its beat; either gives
// a registered result only when a report is due
// flow: one item at a time; a waiting result holds the item in eval
// reset: empty window, next sample reported, threshold 5
module battery_level_monitor #(
    parameter int WINDOW_DEPTH = blm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blm_pkg::PADDR_W-1:0]   paddr,
    input  logic [blm_pkg::PDATA_W-1:0]   pwdata,
    output logic [blm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  blm_pkg::blm_in_t              item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output blm_pkg::blm_out_t             result
);

`include "battery_level_monitor_defines.svh"

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_RUN  = 2'd1;
    localparam logic [1:0] T_EVAL = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [blm_pkg::LEVEL_W-1:0]     thr_reg;
    logic                            force_reg, force_next;
    logic [7:0]                      rep_level_reg, rep_level_next;
    logic [2:0]                      rep_state_reg, rep_state_next;
    logic [blm_pkg::BSTATE_W-1:0]    bstate_reg, bstate_next;
    logic                            err_reg, err_next;
    logic [blm_pkg::MV_W-1:0]        mean_reg, mean_next;
    logic                            result_valid_reg, result_valid_next;
    blm_pkg::blm_out_t               result_reg, result_next;

    blm_pkg::seq_ctrl_t              ctrl;
    blm_pkg::seq_stat_t              stat;

    logic                            item_fire;
    logic                            cfg_write;
    logic [blm_pkg::LEVEL_W-1:0]     level;
    logic [7:0]                      diff;
    logic                            report;
    logic                            can_load;
    logic [blm_pkg::BSTATE_W-1:0]    chg_state;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign prdata     = (paddr[2] == blm_pkg::REG_CHANGE_THRESHOLD)
                        ? blm_pkg::PDATA_W'(thr_reg) : '0;

    assign item_ready = (state_reg == T_IDLE);
    assign item_fire  = item_valid && item_ready;

    assign ctrl.start = item_fire && (item.cmd == blm_pkg::CMD_SAMPLE) && item.read_ok;
    assign ctrl.mv    = item.sample_mv;

    blm_seq #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    always_comb
    begin
        chg_state = blm_pkg::BS_IDLE;
        if (item.charger_valid)
        begin
            if (item.charge_status == blm_pkg::CHG_ACTIVE)
            begin
                chg_state = blm_pkg::BS_CHARGING;
            end
            else if (item.charge_status == blm_pkg::CHG_FULL)
            begin
                chg_state = blm_pkg::BS_FULL;
            end
        end
    end

    // report decision
    assign level    = err_reg ? '0 : blm_pkg::soc_level(mean_reg);
    assign diff     = ({1'b0, level} > rep_level_reg) ? ({1'b0, level} - rep_level_reg)
                                                      : (rep_level_reg - {1'b0, level});
    assign report   = force_reg || (diff >= {1'b0, thr_reg})
                      || ({1'b0, bstate_reg} != rep_state_reg);
    assign can_load = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next        = state_reg;
        force_next        = force_reg;
        rep_level_next    = rep_level_reg;
        rep_state_next    = rep_state_reg;
        bstate_next       = bstate_reg;
        err_next          = err_reg;
        mean_next         = mean_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        case (state_reg)
            T_IDLE:
            begin
                if (item_fire)
                begin
                    if (item.cmd == blm_pkg::CMD_WAKE)
                    begin
                        force_next = 1'b1;
                    end
                    else if (!item.read_ok)
                    begin
                        err_next    = 1'b1;
                        bstate_next = blm_pkg::BS_ERROR;
                        state_next  = T_EVAL;
                    end
                    else
                    begin
                        err_next    = 1'b0;
                        bstate_next = chg_state;
                        state_next  = T_RUN;
                    end
                end
            end
            T_RUN:
            begin
                if (stat.done)
                begin
                    mean_next  = stat.mean;
                    state_next = T_EVAL;
                end
            end
            T_EVAL:
            begin
                if (can_load)
                begin
                    if (report)
                    begin
                        result_next.level_percent = level;
                        result_next.battery_state = bstate_reg;
                        result_valid_next         = 1'b1;
                        rep_level_next            = {1'b0, level};
                        rep_state_next            = {1'b0, bstate_reg};
                        force_next                = 1'b0;
                    end
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            thr_reg          <= blm_pkg::THRESHOLD_RST;
            force_reg        <= 1'b1;
            rep_level_reg    <= blm_pkg::REPORTED_LEVEL_RST;
            rep_state_reg    <= blm_pkg::REPORTED_STATE_NONE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            force_reg        <= force_next;
            rep_level_reg    <= rep_level_next;
            rep_state_reg    <= rep_state_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write && (paddr[2] == blm_pkg::REG_CHANGE_THRESHOLD))
            begin
                thr_reg <= pwdata[blm_pkg::LEVEL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bstate_reg <= bstate_next;
        err_reg    <= err_next;
        mean_reg   <= mean_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `BLM_ASSERT_HOLDS(a_ready_seq_idle, clk, rst_n, item_ready, !stat.busy)
    `BLM_ASSERT_HOLDS(a_done_in_run, clk, rst_n, stat.done, state_reg == T_RUN)
    `BLM_ASSERT_NEXT(a_report_loads, clk, rst_n, (state_reg == T_EVAL) && can_load && report, result_valid && (result.level_percent == $past(level)))
    `BLM_ASSERT_HOLDS(a_level_range, clk, rst_n, result_valid, result.level_percent <= blm_pkg::LEVEL_MAX)

endmodule

// ===== tb/battery_level_monitor_checker.sv =====
`timescale 1ns / 100ps

module battery_level_monitor_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [blm_pkg::PADDR_W-1:0] paddr,
    input  logic [blm_pkg::PDATA_W-1:0] pwdata,
    input  logic                      item_valid,
    input  logic                      item_ready,
    input  blm_pkg::blm_in_t          item,
    input  logic                      result_valid,
    input  logic                      result_ready,
    input  blm_pkg::blm_out_t         result,
    output int                        fail_count,
    output int                        reports_due,
    output int                        reports_seen
);

    localparam int DEPTH     = 4;
    localparam int MV_FLOOR  = 3200;
    localparam int MV_CEIL   = 4100;
    localparam int MV_PITCH  = 100;
    localparam logic [blm_pkg::PADDR_W-1:0] ADDR_THRESHOLD =
        {blm_pkg::REG_CHANGE_THRESHOLD, 2'b00};
    localparam logic [blm_pkg::LEVEL_W-1:0] PCT_STEPS [10] =
        '{7'd0, 7'd2, 7'd4, 7'd8, 7'd15, 7'd30, 7'd50, 7'd70, 7'd90, 7'd100};

    logic [blm_pkg::MV_W-1:0]    readings [DEPTH];
    logic [$clog2(DEPTH)-1:0]    slot;
    logic [2:0]                  filled;
    logic                        wake_pending;
    logic [7:0]                  prior_level;
    logic [2:0]                  prior_state;
    logic [blm_pkg::LEVEL_W-1:0] threshold;
    blm_pkg::blm_out_t           reports_q [$];

    function automatic logic [blm_pkg::LEVEL_W-1:0] percent_of(input int unsigned mv);
        if (mv >= MV_CEIL)
        begin
            return blm_pkg::LEVEL_MAX;
        end
        if (mv <= MV_FLOOR)
        begin
            return '0;
        end
        return PCT_STEPS[(mv - MV_FLOOR) / MV_PITCH];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned                 total;
        int unsigned                 gap;
        logic [blm_pkg::LEVEL_W-1:0] lvl;
        logic [1:0]                  st;
        blm_pkg::blm_out_t           exp_r;
        blm_pkg::blm_out_t           got_r;
        if (!rst_n)
        begin
            slot         = '0;
            filled       = '0;
            wake_pending = 1'b1;
            prior_level  = blm_pkg::REPORTED_LEVEL_RST;
            prior_state  = blm_pkg::REPORTED_STATE_NONE;
            threshold    = blm_pkg::THRESHOLD_RST;
            reports_q.delete();
            fail_count   = 0;
            reports_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD)
            begin
                threshold = pwdata[blm_pkg::LEVEL_W-1:0];
            end

            if (item_valid && item_ready)
            begin
                if (item.cmd == blm_pkg::CMD_WAKE)
                begin
                    wake_pending = 1'b1;
                end
                else
                begin
                    lvl = '0;
                    st  = blm_pkg::BS_IDLE;
                    if (!item.read_ok)
                    begin
                        st = blm_pkg::BS_ERROR;
                    end
                    else
                    begin
                        readings[slot] = item.sample_mv;
                        slot = slot + 1'b1;
                        if (filled < DEPTH)
                        begin
                            filled = filled + 1'b1;
                        end
                        total = 0;
                        for (int k = 0; k < filled; k++)
                        begin
                            total += readings[k];
                        end
                        lvl = percent_of(total / filled);
                        if (item.charger_valid && item.charge_status == blm_pkg::CHG_ACTIVE)
                        begin
                            st = blm_pkg::BS_CHARGING;
                        end
                        else if (item.charger_valid
                                 && item.charge_status == blm_pkg::CHG_FULL)
                        begin
                            st = blm_pkg::BS_FULL;
                        end
                    end
                    gap = (lvl > prior_level) ? lvl - prior_level : prior_level - lvl;
                    if (wake_pending || gap >= threshold || {1'b0, st} != prior_state)
                    begin
                        exp_r.level_percent = lvl;
                        exp_r.battery_state = st;
                        reports_q.push_back(exp_r);
                        prior_level  = {1'b0, lvl};
                        prior_state  = {1'b0, st};
                        wake_pending = 1'b0;
                    end
                end
            end

            if (result_valid && result_ready)
            begin
                got_r = result;
                if (reports_q.size() == 0)
                begin
                    $error("result beat with no report pending: level %0d state %0d",
                           got_r.level_percent, got_r.battery_state);
                    fail_count++;
                end
                else
                begin
                    exp_r = reports_q.pop_front();
                    reports_seen++;
                    if (got_r.level_percent !== exp_r.level_percent)
                    begin
                        $error("level_percent: expected %0d, got %0d",
                               exp_r.level_percent, got_r.level_percent);
                        fail_count++;
                    end
                    if (got_r.battery_state !== exp_r.battery_state)
                    begin
                        $error("battery_state: expected %0d, got %0d",
                               exp_r.battery_state, got_r.battery_state);
                        fail_count++;
                    end
                end
            end
        end
        reports_due = reports_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_PCT      = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [1:0] CHG_OTHER    = 2'd0;
    localparam logic [1:0] CHG_RESERVED = 2'd3;
    localparam logic [blm_pkg::PADDR_W-1:0] ADDR_THRESHOLD =
        {blm_pkg::REG_CHANGE_THRESHOLD, 2'b00};

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [blm_pkg::PADDR_W-1:0] paddr = '0;
    logic [blm_pkg::PDATA_W-1:0] pwdata = '0;
    logic [blm_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    logic                        item_valid = 1'b0;
    logic                        item_ready;
    blm_pkg::blm_in_t            item = '0;
    logic                        result_valid;
    logic                        result_ready = 1'b0;
    blm_pkg::blm_out_t           result;

    int   fail_count;
    int   reports_due;
    int   reports_seen;
    int   quiet = 0;
    logic calm = 1'b0;
    logic start_hold = 1'b0;
    int   cur_mv = 3700;
    logic chg_ok = 1'b1;
    logic [1:0] chg_code = blm_pkg::CHG_ACTIVE;
    int   n_good;
    int   n_err;
    int   n_wake;
    int   n_settings;

    always #10 clk = ~clk;

    battery_level_monitor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    battery_level_monitor_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .reports_due  (reports_due),
        .reports_seen (reports_seen)
    );

    // cycles without any beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // result side, with one long hold-off on request
    initial
    begin
        int   stall_left;
        logic hold_used;
        stall_left = 0;
        hold_used  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && start_hold && !hold_used)
            begin
                stall_left = HOLD_CYCLES;
                hold_used  = 1'b1;
            end
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic blm_pkg::blm_in_t sample_of(input logic [blm_pkg::MV_W-1:0] mv,
                                                   input logic ok, input logic cv,
                                                   input logic [1:0] cs);
        blm_pkg::blm_in_t v;
        v.cmd           = blm_pkg::CMD_SAMPLE;
        v.sample_mv     = mv;
        v.read_ok       = ok;
        v.charger_valid = cv;
        v.charge_status = cs;
        return v;
    endfunction

    function automatic blm_pkg::blm_in_t wake_of();
        blm_pkg::blm_in_t v;
        v.cmd           = blm_pkg::CMD_WAKE;
        v.sample_mv     = blm_pkg::MV_W'($urandom_range(0, 8191));
        v.read_ok       = 1'($urandom_range(0, 1));
        v.charger_valid = 1'($urandom_range(0, 1));
        v.charge_status = 2'($urandom_range(0, 3));
        return v;
    endfunction

    task automatic send_item(input blm_pkg::blm_in_t v);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= v;
        do
            @(posedge clk);
        while (!item_ready);
        if (v.cmd == blm_pkg::CMD_WAKE)
        begin
            n_wake++;
        end
        else if (v.read_ok)
        begin
            n_good++;
        end
        else
        begin
            n_err++;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (reports_due != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [blm_pkg::PADDR_W-1:0] addr,
                             input logic [blm_pkg::PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_threshold(input int pct);
        drain();
        write_reg(ADDR_THRESHOLD, blm_pkg::PDATA_W'(pct));
        n_settings++;
    endtask

    // voltage mostly drifts, with jumps and the odd wild reading
    task automatic run_random(input int count, input int hold_at);
        int                       pick;
        logic [blm_pkg::MV_W-1:0] mv;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
            begin
                start_hold = 1'b1;
            end
            if ($urandom_range(0, 99) < 5)
            begin
                send_item(wake_of());
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    cur_mv = cur_mv + $urandom_range(0, 160) - 80;
                    if (cur_mv < 2900)
                    begin
                        cur_mv = 2900;
                    end
                    if (cur_mv > 4400)
                    begin
                        cur_mv = 4400;
                    end
                    mv = blm_pkg::MV_W'(cur_mv);
                end
                else if (pick < 92)
                begin
                    cur_mv = $urandom_range(3000, 4300);
                    mv = blm_pkg::MV_W'(cur_mv);
                end
                else
                begin
                    mv = blm_pkg::MV_W'($urandom_range(0, 8191));
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    chg_ok   = ($urandom_range(0, 7) != 0);
                    chg_code = 2'($urandom_range(0, 3));
                end
                send_item(sample_of(mv, $urandom_range(0, 99) >= 7, chg_ok, chg_code));
            end
        end
    endtask

    initial
    begin
        n_good = 0;
        n_err = 0;
        n_wake = 0;
        n_settings = 1;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed, threshold at its reset value
        send_item(sample_of(13'd3650, 1'b1, 1'b1, blm_pkg::CHG_ACTIVE));
        send_item(sample_of(13'd0, 1'b1, 1'b1, blm_pkg::CHG_ACTIVE));
        send_item(sample_of(13'd8191, 1'b1, 1'b1, blm_pkg::CHG_FULL));
        send_item(sample_of(13'd8191, 1'b0, 1'b1, blm_pkg::CHG_FULL));
        send_item(sample_of(13'd3200, 1'b1, 1'b0, blm_pkg::CHG_ACTIVE));
        send_item(sample_of(13'd3200, 1'b1, 1'b1, CHG_RESERVED));
        send_item(sample_of(13'd3200, 1'b1, 1'b1, CHG_OTHER));
        send_item(sample_of(13'd3200, 1'b1, 1'b1, CHG_OTHER));
        send_item(sample_of(13'd3199, 1'b1, 1'b1, CHG_OTHER));
        send_item(sample_of(13'd3201, 1'b1, 1'b1, CHG_OTHER));
        send_item(sample_of(13'd3299, 1'b1, 1'b1, CHG_OTHER));
        send_item(sample_of(13'd3300, 1'b1, 1'b1, CHG_OTHER));
        send_item(sample_of(13'd4099, 1'b1, 1'b1, blm_pkg::CHG_ACTIVE));
        send_item(sample_of(13'd4100, 1'b1, 1'b1, blm_pkg::CHG_ACTIVE));
        send_item(sample_of(13'd4101, 1'b1, 1'b1, blm_pkg::CHG_ACTIVE));
        send_item(sample_of(13'd4100, 1'b1, 1'b1, blm_pkg::CHG_FULL));
        send_item(wake_of());
        send_item(sample_of(13'd4100, 1'b1, 1'b1, blm_pkg::CHG_FULL));
        send_item(wake_of());
        send_item(sample_of(13'd0, 1'b0, 1'b0, CHG_OTHER));
        send_item(sample_of(13'd0, 1'b0, 1'b0, CHG_OTHER));
        send_item(sample_of(13'd3750, 1'b1, 1'b0, blm_pkg::CHG_FULL));
        send_item(sample_of(13'd3750, 1'b1, 1'b1, CHG_RESERVED));

        set_threshold(0);
        run_random(300, 60);
        set_threshold(100);
        run_random(250, -1);
        set_threshold(127);
        run_random(200, -1);
        calm = 1'b1;
        set_threshold(1);
        run_random(300, -1);
        calm = 1'b0;
        for (int p = 0; p < 3; p++)
        begin
            set_threshold($urandom_range(0, 100));
            run_random(180, -1);
        end

        drain();
        $display("sent %0d good samples, %0d read errors and %0d wake commands",
                 n_good, n_err, n_wake);
        $display("checked %0d reports over %0d threshold settings incl. 0, 100, 127",
                 reports_seen, n_settings);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/blm_pkg.sv
hw/rtl/blm_window.sv
hw/rtl/blm_seq.sv
hw/rtl/battery_level_monitor.sv
tb/battery_level_monitor_checker.sv
tb/testbench.sv
